FILE: rtl/char_range_set_expander_macros.svh
// Assertion macros shared by the character set expander modules.
`ifndef CHAR_RANGE_SET_EXPANDER_MACROS_SVH
`define CHAR_RANGE_SET_EXPANDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CSX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/csx_pkg.sv
// Types, constants and helpers of the character set expander.
package csx_pkg;

   localparam int unsigned CNT_W = 5;
   localparam logic [CNT_W-1:0] MAX_SET_SIZE = 5'd26;
   localparam logic [7:0] HYPHEN = 8'h2D;

   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_AW = 2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_LEADING     = 3'd1;
   localparam logic [2:0] ST_TWO_HYPHENS = 3'd2;
   localparam logic [2:0] ST_DESCENDING  = 3'd3;
   localparam logic [2:0] ST_MIXED       = 3'd4;
   localparam logic [2:0] ST_TOO_MANY    = 3'd5;
   localparam logic [2:0] ST_ILLEGAL     = 3'd6;
   localparam logic [2:0] ST_TRAILING    = 3'd7;

   localparam logic [1:0] CLS_NONE  = 2'd0;
   localparam logic [1:0] CLS_DIGIT = 2'd1;
   localparam logic [1:0] CLS_LOWER = 2'd2;
   localparam logic [1:0] CLS_UPPER = 2'd3;

   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // One command from front to back: a run of characters or a final status.
   typedef struct packed {
      logic             is_status;
      logic [7:0]       first_char;
      logic [CNT_W-1:0] run_len;
      logic [2:0]       status;
   } cmd_type;

   function automatic logic [1:0] char_class(input logic [7:0] c);
      logic [1:0] cls;
      cls = CLS_NONE;
      if (c >= 8'h30 && c <= 8'h39) begin
         cls = CLS_DIGIT;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         cls = CLS_LOWER;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         cls = CLS_UPPER;
      end
      return cls;
   endfunction

endpackage

FILE: rtl/char_range_set_expander.sv
// Top level of the character set expander: front end, command queue, back end.
//
//  channel | ports                                          | handshake
//  req     | req_char_code, req_string_end                  | req_push / req_full
//  rsp     | rsp_item_kind, rsp_out_char, rsp_status,       | rsp_empty / rsp_pop
//          | rsp_final_flag                                 |
//
// The front end takes one transaction a cycle while the command queue has room.
// The back end loads a command when idle, then emits one result a cycle while its result
// register is free or popped: one per plain character or string end, n for a run of n, at most 26.
// Hyphens and characters dropped after an error reach only the front end and issue no command.
// Synchronous active-high reset clears the parse state, the queue and the output.
// A stall on the result side fills the four-entry queue, then raises req_full.
module char_range_set_expander (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_string_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_out_char,
   output logic [2:0] rsp_status,
   output logic       rsp_final_flag
);
   import csx_pkg::*;

   cmd_type push_cmd, pop_cmd;
   logic    push_valid, q_full, q_empty, q_pop, accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   csx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_code  (req_char_code),
      .string_end (req_string_end),
      .cmd_push   (push_valid),
      .cmd        (push_cmd)
   );

   csx_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   csx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (pop_cmd),
      .cmd_empty      (q_empty),
      .cmd_pop        (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_out_char   (rsp_out_char),
      .rsp_status     (rsp_status),
      .rsp_final_flag (rsp_final_flag)
   );

endmodule

FILE: rtl/csx_front.sv
// Front end: parses spec characters and issues run and status commands.
`include "char_range_set_expander_macros.svh"

module csx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_code,
   input  logic              string_end,
   output logic              cmd_push,
   output csx_pkg::cmd_type  cmd
);
   import csx_pkg::*;

   logic [7:0]       prev_ff, prev_in;
   logic             open_ff, open_in;
   logic [7:0]       start_ff, start_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]       err_ff, err_in;
   logic             at_start_ff, at_start_in;

   logic [1:0]       cls;
   logic [CNT_W-1:0] avail;
   logic [CNT_W-1:0] span_len;
   logic [7:0]       diff;

   assign cls      = char_class(char_code);
   assign avail    = MAX_SET_SIZE - count_ff;
   assign diff     = char_code - start_ff;
   assign span_len = diff[CNT_W-1:0];

   always_comb begin
      prev_in     = prev_ff;
      open_in     = open_ff;
      start_in    = start_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      at_start_in = at_start_ff;
      cmd_push    = 1'b0;
      cmd         = '0;
      if (accept) begin
         if (string_end) begin
            cmd_push       = 1'b1;
            cmd.is_status  = 1'b1;
            cmd.status     = (err_ff != ST_OK) ? err_ff : (open_ff ? ST_TRAILING : ST_OK);
            prev_in        = '0;
            open_in        = 1'b0;
            start_in       = '0;
            count_in       = '0;
            err_in         = ST_OK;
            at_start_in    = 1'b1;
         end else if (err_ff == ST_OK) begin
            at_start_in = 1'b0;
            if (char_code == HYPHEN) begin
               if (at_start_ff) begin
                  err_in = ST_LEADING;
               end else if (open_ff) begin
                  err_in = ST_TWO_HYPHENS;
               end else begin
                  start_in = prev_ff;
                  open_in  = 1'b1;
               end
            end else if (cls == CLS_NONE) begin
               err_in = ST_ILLEGAL;
            end else if (!open_ff) begin
               if (count_ff >= MAX_SET_SIZE) begin
                  err_in = ST_TOO_MANY;
               end else begin
                  cmd_push       = 1'b1;
                  cmd.first_char = char_code;
                  cmd.run_len    = CNT_W'(1);
                  count_in       = count_ff + CNT_W'(1);
                  prev_in        = char_code;
               end
            end else if (char_class(start_ff) != cls) begin
               err_in = ST_MIXED;
            end else if (char_code < start_ff) begin
               err_in = ST_DESCENDING;
            end else begin
               cmd.first_char = start_ff + 8'd1;
               if (span_len > avail) begin
                  cmd_push    = (avail != '0);
                  cmd.run_len = avail;
                  err_in      = ST_TOO_MANY;
               end else begin
                  cmd_push    = (span_len != '0);
                  cmd.run_len = span_len;
                  count_in    = count_ff + span_len;
                  open_in     = 1'b0;
                  prev_in     = char_code;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         open_ff     <= 1'b0;
         start_ff    <= '0;
         count_ff    <= '0;
         err_ff      <= ST_OK;
         at_start_ff <= 1'b1;
      end else begin
         prev_ff     <= prev_in;
         open_ff     <= open_in;
         start_ff    <= start_in;
         count_ff    <= count_in;
         err_ff      <= err_in;
         at_start_ff <= at_start_in;
      end
   end

   `CSX_ASSERT_NOW(a_count_capped, 1'b1, count_ff <= MAX_SET_SIZE, "emitted count over capacity")

endmodule

FILE: rtl/csx_cmd_queue.sv
// Small command queue between front and back end.
`include "char_range_set_expander_macros.svh"

module csx_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  csx_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output csx_pkg::cmd_type  pop_data,
   output logic              empty
);
   import csx_pkg::*;

   cmd_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (Q_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `CSX_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= (Q_AW+1)'(Q_DEPTH), "queue count over depth")
   `CSX_ASSERT_NOW(a_ptr_gap, 1'b1, Q_AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[Q_AW-1:0], "queue pointers out of step")

endmodule

FILE: rtl/csx_back.sv
// Back end: expands runs into the result register, one character a cycle while it is free.
`include "char_range_set_expander_macros.svh"

module csx_back (
   input  logic              clock,
   input  logic              reset,
   input  csx_pkg::cmd_type  cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_item_kind,
   output logic [7:0]        rsp_out_char,
   output logic [2:0]        rsp_status,
   output logic              rsp_final_flag
);
   import csx_pkg::*;

   logic             busy_ff, busy_in;
   logic             stat_ff, stat_in;
   logic [7:0]       char_ff, char_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [2:0]       code_ff, code_in;

   logic             out_valid_ff, out_valid_in;
   logic             out_kind_ff, out_kind_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic [2:0]       out_status_ff, out_status_in;

   logic             out_free;

   assign out_free = !out_valid_ff || rsp_pop;
   assign cmd_pop  = !busy_ff && !cmd_empty;

   always_comb begin
      busy_in       = busy_ff;
      stat_in       = stat_ff;
      char_in       = char_ff;
      left_in       = left_ff;
      code_in       = code_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_kind_in   = out_kind_ff;
      out_char_in   = out_char_ff;
      out_status_in = out_status_ff;
      if (busy_ff && out_free) begin
         out_valid_in = 1'b1;
         if (stat_ff) begin
            out_kind_in   = KIND_STATUS;
            out_char_in   = '0;
            out_status_in = code_ff;
            busy_in       = 1'b0;
         end else begin
            out_kind_in   = KIND_CHAR;
            out_char_in   = char_ff;
            out_status_in = ST_OK;
            char_in       = char_ff + 8'd1;
            left_in       = left_ff - CNT_W'(1);
            busy_in       = (left_ff != CNT_W'(1));
         end
      end else if (cmd_pop) begin
         busy_in = 1'b1;
         stat_in = cmd.is_status;
         char_in = cmd.first_char;
         left_in = cmd.is_status ? CNT_W'(1) : cmd.run_len;
         code_in = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff       <= stat_in;
      char_ff       <= char_in;
      left_ff       <= left_in;
      code_ff       <= code_in;
      out_kind_ff   <= out_kind_in;
      out_char_ff   <= out_char_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_item_kind  = out_kind_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_final_flag = out_kind_ff;

   `CSX_ASSERT_NOW(a_run_nonempty, busy_ff, left_ff != '0, "active run with no characters left")
   `CSX_ASSERT_NEXT(a_load_busy, cmd_pop, busy_ff, "loaded command not active")

endmodule
